@@ rtl/ntfsrl_pkg.sv @@
// Shared types and constants for the NTFS run-list decoder.
// No dependencies; used by ntfs_runlist_decoder.
`default_nettype none

package ntfsrl_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 64;
    localparam int unsigned NBytes = WordW / ByteW;
    localparam int unsigned IdxW   = 4;
    localparam int unsigned KindW  = 2;
    localparam int unsigned CfgIdxW = 1;

    // result kinds
    localparam logic [KindW-1:0] KIND_DATA   = 2'd0;
    localparam logic [KindW-1:0] KIND_SPARSE = 2'd1;
    localparam logic [KindW-1:0] KIND_END    = 2'd2;
    localparam logic [KindW-1:0] KIND_BAD    = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PART_LBA = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SPC      = 1'd1;

    localparam logic [WordW-1:0] PART_LBA_RST = '0;
    localparam logic [ByteW-1:0] SPC_RST      = 8'd8;

    localparam logic [3:0] MAX_FIELD_W = 4'd8;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DELTA  = 4'b0100,
        PH_STOP   = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

@@ rtl/ntfs_runlist_decoder.sv @@
// NTFS data-run list decoder: one run-list byte per transaction in, one run per result.
// Results go through registers P, Q and O; one byte per cycle while not stalled.
// Stage 1 decodes the byte against the run state, stage 2 forms cluster * sectors,
// stage 3 adds the partition start. Stall propagates back only through full stages.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets the decoder to expect a
// header with all accumulators zero, partition start to 0 and sectors per cluster to 8.
`default_nettype none

module ntfs_runlist_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [ntfsrl_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [ntfsrl_pkg::WordW-1:0]   i_cfg_data,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ntfsrl_pkg::ByteW-1:0]   i_list_byte,
    input  wire logic                           i_first_of_list,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ntfsrl_pkg::KindW-1:0]        o_kind,
    output logic [ntfsrl_pkg::WordW-1:0]        o_run_first_vcn,
    output logic signed [ntfsrl_pkg::WordW-1:0] o_run_lcn,
    output logic [ntfsrl_pkg::WordW-1:0]        o_run_start_sector,
    output logic [ntfsrl_pkg::WordW-1:0]        o_run_cluster_count
);

    localparam int unsigned WW = ntfsrl_pkg::WordW;
    localparam int unsigned BW = ntfsrl_pkg::ByteW;
    localparam int unsigned NB = ntfsrl_pkg::NBytes;
    localparam int unsigned IW = ntfsrl_pkg::IdxW;
    localparam int unsigned KW = ntfsrl_pkg::KindW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WW-1:0] r_part_lba;
    logic [BW-1:0] r_spc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_lba <= ntfsrl_pkg::PART_LBA_RST;
            r_spc      <= ntfsrl_pkg::SPC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntfsrl_pkg::CFG_PART_LBA: r_part_lba <= i_cfg_data;
                ntfsrl_pkg::CFG_SPC:      r_spc      <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves when empty or when the
    // stage after it moves, so bubbles collapse under output stall.
    // ------------------------------------------------------------------
    logic r_p_vld, r_q_vld, r_o_vld;
    logic o_adv, q_adv, p_adv, in_acc;

    assign o_adv   = !r_o_vld || !i_stall;
    assign q_adv   = !r_q_vld || o_adv;
    assign p_adv   = !r_p_vld || q_adv;
    assign in_acc  = i_valid && p_adv;
    assign o_stall = !p_adv;

    // ------------------------------------------------------------------
    // Run decoder state
    // ------------------------------------------------------------------
    ntfsrl_pkg::t_phase r_phase, n_phase;
    logic [3:0]    r_len_w,   n_len_w;
    logic [3:0]    r_ofs_w,   n_ofs_w;
    logic [IW-1:0] r_idx,     n_idx;
    logic [WW-1:0] r_len_acc, n_len_acc;
    logic [WW-1:0] r_dlt_acc, n_dlt_acc;
    logic [WW-1:0] r_clu_acc, n_clu_acc;
    logic [WW-1:0] r_vcn_acc, n_vcn_acc;

    // decoded result of the byte being accepted
    logic          res_vld;
    logic [KW-1:0] res_kind;
    logic [WW-1:0] res_vcn, res_lcn, res_cnt;

    always_comb begin
        ntfsrl_pkg::t_phase ph;
        logic [WW-1:0]      clu, vcn;
        logic [WW-1:0]      merged_len, merged_dlt, ext_dlt, lcn_sum;
        logic [IW-1:0]      idx_inc;
        logic [3:0]         lo_nib, hi_nib;

        n_phase   = r_phase;
        n_len_w   = r_len_w;
        n_ofs_w   = r_ofs_w;
        n_idx     = r_idx;
        n_len_acc = r_len_acc;
        n_dlt_acc = r_dlt_acc;
        n_clu_acc = r_clu_acc;
        n_vcn_acc = r_vcn_acc;
        res_vld   = 1'b0;
        res_kind  = ntfsrl_pkg::KIND_DATA;
        res_vcn   = '0;
        res_lcn   = '0;
        res_cnt   = '0;

        // start of a new list clears the running sums and forces a header
        ph  = i_first_of_list ? ntfsrl_pkg::PH_HEADER : r_phase;
        clu = i_first_of_list ? '0 : r_clu_acc;
        vcn = i_first_of_list ? '0 : r_vcn_acc;

        lo_nib  = i_list_byte[3:0];
        hi_nib  = i_list_byte[7:4];
        idx_inc = r_idx + IW'(1);

        // drop the current byte into its little-endian slot
        merged_len = r_len_acc;
        merged_dlt = r_dlt_acc;
        for (int k = 0; k < NB; k++) begin
            if (r_idx[2:0] == 3'(k)) begin
                merged_len[k*BW +: BW] = i_list_byte;
                merged_dlt[k*BW +: BW] = r_dlt_acc[k*BW +: BW] | i_list_byte;
            end
        end
        for (int k = 0; k < NB; k++) begin
            if (r_idx[2:0] == 3'(k))
                merged_len[k*BW +: BW] = r_len_acc[k*BW +: BW] | i_list_byte;
        end

        // sign extension: the byte that ends the delta carries its sign bit
        for (int k = 0; k < NB; k++) begin
            ext_dlt[k*BW +: BW] = (4'(k) < r_ofs_w) ? merged_dlt[k*BW +: BW]
                                                     : {BW{i_list_byte[BW-1]}};
        end
        lcn_sum = clu + ext_dlt;

        if (in_acc) begin
            n_clu_acc = clu;
            n_vcn_acc = vcn;
            unique case (ph)
                ntfsrl_pkg::PH_HEADER: begin
                    if (i_list_byte == '0) begin
                        // end marker: report total length seen
                        n_phase  = ntfsrl_pkg::PH_STOP;
                        res_vld  = 1'b1;
                        res_kind = ntfsrl_pkg::KIND_END;
                        res_vcn  = vcn;
                    end else begin
                        n_len_w = lo_nib;
                        n_ofs_w = hi_nib;
                        if (lo_nib == '0 || lo_nib > ntfsrl_pkg::MAX_FIELD_W
                            || hi_nib > ntfsrl_pkg::MAX_FIELD_W) begin
                            n_phase  = ntfsrl_pkg::PH_STOP;
                            res_vld  = 1'b1;
                            res_kind = ntfsrl_pkg::KIND_BAD;
                        end else begin
                            n_idx     = '0;
                            n_len_acc = '0;
                            n_dlt_acc = '0;
                            n_phase   = ntfsrl_pkg::PH_LENGTH;
                        end
                    end
                end
                ntfsrl_pkg::PH_LENGTH: begin
                    n_len_acc = merged_len;
                    n_idx     = idx_inc;
                    if (idx_inc >= r_len_w) begin
                        if (r_ofs_w == '0) begin
                            // sparse run: no cluster delta follows
                            n_vcn_acc = vcn + merged_len;
                            n_phase   = ntfsrl_pkg::PH_HEADER;
                            res_vld   = 1'b1;
                            res_kind  = ntfsrl_pkg::KIND_SPARSE;
                            res_vcn   = vcn;
                            res_cnt   = merged_len;
                        end else begin
                            n_idx   = '0;
                            n_phase = ntfsrl_pkg::PH_DELTA;
                        end
                    end
                end
                ntfsrl_pkg::PH_DELTA: begin
                    n_dlt_acc = merged_dlt;
                    n_idx     = idx_inc;
                    if (idx_inc >= r_ofs_w) begin
                        n_dlt_acc = ext_dlt;
                        n_clu_acc = lcn_sum;
                        n_vcn_acc = vcn + r_len_acc;
                        n_phase   = ntfsrl_pkg::PH_HEADER;
                        res_vld   = 1'b1;
                        res_kind  = ntfsrl_pkg::KIND_DATA;
                        res_vcn   = vcn;
                        res_lcn   = lcn_sum;
                        res_cnt   = r_len_acc;
                    end
                end
                ntfsrl_pkg::PH_STOP: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ntfsrl_pkg::PH_HEADER;
            r_len_w   <= '0;
            r_ofs_w   <= '0;
            r_idx     <= '0;
            r_len_acc <= '0;
            r_dlt_acc <= '0;
            r_clu_acc <= '0;
            r_vcn_acc <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len_w   <= n_len_w;
            r_ofs_w   <= n_ofs_w;
            r_idx     <= n_idx;
            r_len_acc <= n_len_acc;
            r_dlt_acc <= n_dlt_acc;
            r_clu_acc <= n_clu_acc;
            r_vcn_acc <= n_vcn_acc;
        end
    end

    // ------------------------------------------------------------------
    // Stage P: decoded run waiting for the sector multiply
    // ------------------------------------------------------------------
    logic [KW-1:0] r_p_kind;
    logic [WW-1:0] r_p_vcn, r_p_lcn, r_p_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_p_vld <= 1'b0;
        else if (p_adv)
            r_p_vld <= in_acc && res_vld;
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_p_kind <= res_kind;
            r_p_vcn  <= res_vcn;
            r_p_lcn  <= res_lcn;
            r_p_cnt  <= res_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: cluster * sectors per cluster, mod 2^64
    // ------------------------------------------------------------------
    logic [KW-1:0] r_q_kind;
    logic [WW-1:0] r_q_vcn, r_q_lcn, r_q_cnt, r_q_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_q_vld <= 1'b0;
        else if (q_adv)
            r_q_vld <= r_p_vld;
    end

    always_ff @(posedge i_clk) begin
        if (q_adv) begin
            r_q_kind <= r_p_kind;
            r_q_vcn  <= r_p_vcn;
            r_q_lcn  <= r_p_lcn;
            r_q_cnt  <= r_p_cnt;
            r_q_prod <= WW'(r_p_lcn * WW'(r_spc));
        end
    end

    // ------------------------------------------------------------------
    // Stage O: output register; sector only meaningful for data runs
    // ------------------------------------------------------------------
    logic [KW-1:0] r_o_kind;
    logic [WW-1:0] r_o_vcn, r_o_lcn, r_o_sec, r_o_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_vld <= 1'b0;
        else if (o_adv)
            r_o_vld <= r_q_vld;
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_o_kind <= r_q_kind;
            r_o_vcn  <= r_q_vcn;
            r_o_lcn  <= r_q_lcn;
            r_o_cnt  <= r_q_cnt;
            r_o_sec  <= (r_q_kind == ntfsrl_pkg::KIND_DATA) ? r_part_lba + r_q_prod : '0;
        end
    end

    assign o_valid             = r_o_vld;
    assign o_kind              = r_o_kind;
    assign o_run_first_vcn     = r_o_vcn;
    assign o_run_lcn           = $signed(r_o_lcn);
    assign o_run_start_sector  = r_o_sec;
    assign o_run_cluster_count = r_o_cnt;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for ntfs_runlist_decoder: directed and random run lists,
// with random sender gaps and receiver stalls. Depends on ntfsrl_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
    import ntfsrl_pkg::*;

    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RAND_PER_PHASE = 235;   // list bytes per configuration phase
    localparam int TAIL_CYCLES    = 8;     // pipeline is 3 deep, leave some margin

    // one input transaction
    typedef struct packed {
        logic [ByteW-1:0] list_byte;
        logic             first_mark;
    } list_item_t;

    // one decoded run as the block should report it
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [WordW-1:0] first_vcn;
        logic [WordW-1:0] lcn;
        logic [WordW-1:0] start_sector;
        logic [WordW-1:0] cluster_count;
    } run_rec_t;

    // clock, reset and DUT ports; every input starts at a known value
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_idx = '0;
    logic [WordW-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [ByteW-1:0]         i_list_byte = '0;
    logic                     i_first_of_list = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [KindW-1:0]         o_kind;
    logic [WordW-1:0]         o_run_first_vcn;
    logic signed [WordW-1:0]  o_run_lcn;
    logic [WordW-1:0]         o_run_start_sector;
    logic [WordW-1:0]         o_run_cluster_count;

    // stimulus and expectation stores
    list_item_t pending[$];     // bytes waiting for the driver
    run_rec_t   runs_due[$];    // decoded runs not yet seen on the output
    list_item_t cur_item;
    run_rec_t   want;
    int         list_bytes = 0;
    int         errors = 0;
    int         cycles = 0;
    logic       byte_taken = 1'b0;

    // sender burst/gap and receiver stall pattern state
    int         burst_left = 1;
    int         gap_left = 0;
    int         stall_left = 0;
    logic       stall_hold = 1'b0;

    // decoder shadow: configuration copy and run-list state
    logic [WordW-1:0] part_lba = PART_LBA_RST;
    logic [ByteW-1:0] spc = SPC_RST;
    t_phase           dec_phase = PH_HEADER;
    logic [3:0]       len_w = '0;
    logic [3:0]       off_w = '0;
    logic [3:0]       byte_idx = '0;
    logic [WordW-1:0] len_acc = '0;
    logic [WordW-1:0] delta_acc = '0;
    logic [WordW-1:0] lcn_sum = '0;
    logic [WordW-1:0] vcn_sum = '0;

    ntfs_runlist_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_list_byte         (i_list_byte),
        .i_first_of_list     (i_first_of_list),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_kind              (o_kind),
        .o_run_first_vcn     (o_run_first_vcn),
        .o_run_lcn           (o_run_lcn),
        .o_run_start_sector  (o_run_start_sector),
        .o_run_cluster_count (o_run_cluster_count)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Run-list decode: advances the shadow state by one accepted byte and
    // queues the run it completes, if any.
    // ------------------------------------------------------------------
    task automatic close_run(input logic sparse);
        run_rec_t r;
        r = '0;
        r.kind          = sparse ? KIND_SPARSE : KIND_DATA;
        r.first_vcn     = vcn_sum;
        r.cluster_count = len_acc;
        if (!sparse) begin
            r.lcn          = lcn_sum;
            // start sector wraps at 64 bits, spc taken exactly as written
            r.start_sector = part_lba + lcn_sum * {56'd0, spc};
        end
        vcn_sum   = vcn_sum + len_acc;
        dec_phase = PH_HEADER;
        runs_due.push_back(r);
    endtask

    task automatic decode_byte(input logic [ByteW-1:0] b, input logic first_mark);
        run_rec_t r;
        int       nbits;
        r = '0;
        // list mark: drop any partial run and take this byte as a header
        if (first_mark) begin
            lcn_sum   = '0;
            vcn_sum   = '0;
            dec_phase = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER: begin
                if (b == 8'h00) begin
                    // terminator: report the total VCN span of the list
                    dec_phase   = PH_STOP;
                    r.kind      = KIND_END;
                    r.first_vcn = vcn_sum;
                    runs_due.push_back(r);
                end else begin
                    len_w = b[3:0];
                    off_w = b[7:4];
                    if (len_w == 4'd0 || len_w > MAX_FIELD_W || off_w > MAX_FIELD_W) begin
                        dec_phase = PH_STOP;
                        r.kind    = KIND_BAD;
                        runs_due.push_back(r);
                    end else begin
                        byte_idx  = '0;
                        len_acc   = '0;
                        delta_acc = '0;
                        dec_phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                len_acc  = len_acc | ({56'd0, b} << (8 * byte_idx[2:0]));
                byte_idx = byte_idx + 4'd1;
                if (byte_idx >= len_w) begin
                    if (off_w == 4'd0) begin
                        close_run(1'b1);
                    end else begin
                        byte_idx  = '0;
                        dec_phase = PH_DELTA;
                    end
                end
            end
            PH_DELTA: begin
                delta_acc = delta_acc | ({56'd0, b} << (8 * byte_idx[2:0]));
                byte_idx  = byte_idx + 4'd1;
                if (byte_idx >= off_w) begin
                    // sign-extend a short delta before the running sum
                    if (off_w < MAX_FIELD_W) begin
                        nbits = 8 * off_w;
                        if (delta_acc[nbits-1])
                            delta_acc = delta_acc | ~((64'd1 << nbits) - 64'd1);
                    end
                    lcn_sum = lcn_sum + delta_acc;
                    close_run(1'b0);
                end
            end
            default: ;   // stopped: byte ignored until the next list mark
        endcase
    endtask

    task automatic report_error(input string what, input run_rec_t exp_run);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch (%s): kind %0d/%0d vcn %h/%h lcn %h/%h sector %h/%h count %h/%h",
                $realtime, what, exp_run.kind, o_kind, exp_run.first_vcn, o_run_first_vcn,
                exp_run.lcn, o_run_lcn, exp_run.start_sector, o_run_start_sector,
                exp_run.cluster_count, o_run_cluster_count);
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks results first, then feeds the accepted input byte to
    // the shadow decoder, so a result at this edge never meets its own item.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (runs_due.size() == 0) begin
                    report_error("nothing expected", '0);
                end else begin
                    want = runs_due.pop_front();
                    if (o_kind !== want.kind || o_run_first_vcn !== want.first_vcn ||
                        o_run_lcn !== want.lcn || o_run_start_sector !== want.start_sector ||
                        o_run_cluster_count !== want.cluster_count)
                        report_error("field", want);
                end
            end
            if (i_valid && !o_stall)
                decode_byte(i_list_byte, i_first_of_list);
        end
        byte_taken <= i_valid && !o_stall;
    end

    // ------------------------------------------------------------------
    // Driver: presents bytes from the pending queue in bursts with random
    // gaps. A stalled transaction holds its payload until taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || byte_taken)) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                cur_item = pending.pop_front();
                i_valid         <= 1'b1;
                i_list_byte     <= cur_item.list_byte;
                i_first_of_list <= cur_item.first_mark;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: runs of stall or flow, each picked at random, of random length
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_hold = ($urandom_range(0, 3) == 0);
            stall_left = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 25);
        end
        stall_left = stall_left - 1;
        i_stall <= stall_hold;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [ByteW-1:0] b, input logic first_mark);
        list_item_t it;
        it.list_byte  = b;
        it.first_mark = first_mark;
        pending.push_back(it);
        list_bytes++;
    endtask

    task automatic add_noise(input int n);
        for (int k = 0; k < n; k++)
            add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // header plus the first 'keep' field bytes of a run (keep < lw + ow truncates)
    task automatic add_run(input int lw, input int ow, input logic first_mark, input int keep);
        add_byte(8'(ow * 16 + lw), first_mark);
        for (int k = 0; k < keep; k++)
            add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // one run list: mostly well formed, sometimes cut short or malformed
    task automatic add_list();
        int         n_runs;
        int         lw;
        int         ow;
        int         pick;
        logic       first_mark;
        logic [3:0] hi;
        logic [3:0] lo;
        first_mark = ($urandom_range(0, 19) != 0);   // rarely no list mark at all
        n_runs = $urandom_range(0, 6);
        for (int k = 0; k < n_runs; k++) begin
            lw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
            if ($urandom_range(0, 6) == 0)
                ow = 0;
            else
                ow = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                // cut short; the next list mark restarts mid-run
                add_run(lw, ow, first_mark, $urandom_range(0, lw + ow - 1));
                return;
            end
            if (pick == 1) begin
                // malformed header, then bytes the stopped decoder drops
                case ($urandom_range(0, 2))
                    0: begin
                        hi = 4'($urandom_range(0, 15));
                        lo = 4'd0;
                    end
                    1: begin
                        hi = 4'($urandom_range(0, 8));
                        lo = 4'($urandom_range(9, 15));
                    end
                    default: begin
                        hi = 4'($urandom_range(9, 15));
                        lo = 4'($urandom_range(1, 8));
                    end
                endcase
                add_byte({hi, lo}, first_mark);
                add_noise($urandom_range(0, 3));
                return;
            end
            add_run(lw, ow, first_mark, lw + ow);
            first_mark = 1'b0;
        end
        add_byte(8'h00, first_mark);
        if ($urandom_range(0, 3) == 0)
            add_noise($urandom_range(1, 4));
    endtask

    task automatic add_random_traffic(input int target);
        int stop_at;
        stop_at = list_bytes + target;
        while (list_bytes < stop_at)
            add_list();
    endtask

    // sender holds off until every queued byte is taken and every run reported,
    // then lets the pipeline drain bytes that produce no result
    task automatic wait_idle();
        while (pending.size() != 0 || i_valid || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_PART_LBA)
            part_lba = val;
        else
            spc = val[ByteW-1:0];
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset configuration (start 0, 8 sectors per cluster)
        // bytes before any list mark decode from the reset state; negative 1-byte delta
        add_byte(8'h11, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        // sparse run with zero length
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        // full 8-byte delta of all ones, no sign extension
        add_byte(8'h81, 1'b0);
        add_byte(8'h01, 1'b0);
        for (int k = 0; k < 8; k++)
            add_byte(8'hFF, 1'b0);
        // terminator, then a byte the stopped decoder ignores
        add_byte(8'h00, 1'b0);
        add_byte(8'hA5, 1'b0);
        // malformed headers: offset width 9, length width 0, length width 15
        add_byte(8'h90, 1'b1);
        add_byte(8'h10, 1'b1);
        add_byte(8'h0F, 1'b1);
        // restart in the middle of a run, then a positive delta
        add_byte(8'h21, 1'b1);
        add_byte(8'h03, 1'b0);
        add_byte(8'h11, 1'b1);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h7F, 1'b0);
        // empty list
        add_byte(8'h00, 1'b1);

        add_random_traffic(RAND_PER_PHASE);

        // each later phase starts from an idle block with a new setting
        for (int ph = 1; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    write_reg(CFG_PART_LBA, '1);
                    write_reg(CFG_SPC, 64'd128);
                end
                2: begin
                    write_reg(CFG_PART_LBA, '0);
                    write_reg(CFG_SPC, 64'd1);
                end
                3: begin
                    write_reg(CFG_PART_LBA, {$urandom, $urandom});
                    write_reg(CFG_SPC, 64'd0);
                end
                4: begin
                    // junk above the register width must not matter
                    write_reg(CFG_SPC, ({$urandom, $urandom} & ~64'hFF) | 64'hFF);
                    write_reg(CFG_PART_LBA, {$urandom, $urandom});
                end
                default: begin
                    write_reg(CFG_PART_LBA, {$urandom, $urandom});
                    write_reg(CFG_SPC, 64'($urandom_range(1, 128)));
                end
            endcase
            add_random_traffic(RAND_PER_PHASE);
        end

        wait_idle();
        if (errors == 0 && runs_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
